// ===== hdl/rsawc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsawc_pkg: shared types and constants of the RSA split-word cipher
// Register indexes, field widths and the half-word split constants.
// ----------------------------------------------------------------------------
package rsawc_pkg;

  localparam int unsigned ExpW  = 32;
  localparam int unsigned ModW  = 31;
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned CntW  = 5;

  localparam logic [IdxW-1:0] REG_EXPONENT = 2'd0;
  localparam logic [IdxW-1:0] REG_MODULUS  = 2'd1;

  localparam logic [ExpW-1:0] EXPONENT_RESET = 32'd65537;
  localparam logic [ModW-1:0] MODULUS_RESET  = 31'h7FFF_FFFF;

  localparam int unsigned     HALF_SHIFT = 16;
  localparam logic [31:0]     HALF_MASK  = 32'h0000_FFFF;

  localparam logic            CMD_ENCRYPT = 1'b0;
  localparam logic            CMD_DECRYPT = 1'b1;

endpackage

// ===== hdl/rsa_split_word_modexp_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// rsa_split_word_modexp_cipher_unit: RSA-style word cipher
// Right-to-left square-and-multiply modular exponentiation on a shared
// bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Content
//  s_axis    in         tvalid tready tdata tuser     word_a, word_b, cmd
//  m_axis    out        tvalid tready tdata tlast     result_word, last
//  cfg       in         valid ready index data        exponent, modulus
//
// One exponentiation first reduces the base (S_RED), then for each exponent bit
// up to the highest set bit runs a multiply on a set bit (S_MUL) and a square
// (S_SQR) on the one serial multiplier, then passes through S_FIN. An item
// runs two exponentiations, and no new word is taken until it is done, so the
// gap between accepted words is set by the exponent bits and by m_axis_tready.
// Reset is synchronous and loads the register defaults; no clearing pass.
// A finished word waits in the output register while the next item enters.
module rsa_split_word_modexp_cipher_unit
  import rsawc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // [31:0] word_a, [62:32] word_b, [63] zero
  input  logic                 s_axis_tuser,  // [0] cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [WordW-1:0]     m_axis_tdata,  // [31:0] result_word
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IdxW-1:0]      cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_SQR, S_FIN} state_t;

  state_t          state;
  logic [ExpW-1:0] exponent;
  logic [ModW-1:0] modulus;
  logic            cmd_r;
  logic            phase;
  logic [ModW-1:0] op2;
  logic [ModW-1:0] first;
  logic [ExpW-1:0] e_sh;
  logic [ModW-1:0] acc;
  logic [ModW-1:0] sq;
  logic [31:0]     mp;
  logic [ModW-1:0] mc;
  logic [ModW-1:0] macc;
  logic [CntW-1:0] cnt;

  logic [32:0]     t_sum;
  logic [33:0]     d1;
  logic [33:0]     d2;
  logic [ModW-1:0] step;
  logic            step_last;
  logic [ExpW-1:0] e_next;
  logic [ModW-1:0] exp_res;
  logic            out_free;
  logic            in_fire;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // One interleaved step: shift, add the multiplicand, reduce below the modulus.
  always_comb begin
    t_sum     = {1'b0, macc, 1'b0} + (mp[31] ? {2'b00, mc} : 33'd0);
    d2        = {1'b0, t_sum} - {2'b00, modulus, 1'b0};
    d1        = {1'b0, t_sum} - {3'b000, modulus};
    if (!d2[33]) begin
      step = d2[ModW-1:0];
    end else if (!d1[33]) begin
      step = d1[ModW-1:0];
    end else begin
      step = t_sum[ModW-1:0];
    end
    step_last = (cnt == {CntW{1'b1}});
    e_next    = e_sh >> 1;
    if (exponent == '0) begin
      exp_res = {{(ModW-1){1'b0}}, 1'b1};
    end else if (modulus == '0) begin
      exp_res = '0;
    end else begin
      exp_res = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      exponent      <= EXPONENT_RESET;
      modulus       <= MODULUS_RESET;
      m_axis_tvalid <= 1'b0;
      phase         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_EXPONENT: exponent <= cfg_data;
          REG_MODULUS:  modulus  <= cfg_data[ModW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r <= s_axis_tuser;
            phase <= 1'b0;
            if (s_axis_tuser == CMD_ENCRYPT) begin
              mp  <= (s_axis_tdata[31:0] >> HALF_SHIFT) & HALF_MASK;
              op2 <= s_axis_tdata[ModW-1:0] & HALF_MASK[ModW-1:0];
            end else begin
              mp  <= s_axis_tdata[31:0];
              op2 <= s_axis_tdata[62:32];
            end
            mc    <= {{(ModW-1){1'b0}}, 1'b1};
            macc  <= '0;
            cnt   <= '0;
            e_sh  <= exponent;
            acc   <= {{(ModW-1){1'b0}}, 1'b1};
            state <= S_RED;
          end
        end
        S_RED, S_MUL, S_SQR: begin
          macc <= step;
          mp   <= {mp[30:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (step_last) begin
            macc <= '0;
            cnt  <= '0;
            if (state == S_MUL) begin
              acc   <= step;
              mp    <= {1'b0, sq};
              mc    <= sq;
              state <= S_SQR;
            end else begin
              sq <= step;
              if (state == S_SQR) begin
                e_sh <= e_next;
              end
              if ((state == S_SQR) ? (e_next == '0) : (e_sh == '0)) begin
                state <= S_FIN;
              end else if ((state == S_SQR) ? e_next[0] : e_sh[0]) begin
                mp    <= {1'b0, acc};
                mc    <= step;
                state <= S_MUL;
              end else begin
                mp    <= {1'b0, step};
                mc    <= step;
                state <= S_SQR;
              end
            end
          end
        end
        S_FIN: begin
          if (!phase) begin
            if (cmd_r == CMD_DECRYPT || out_free) begin
              if (cmd_r == CMD_ENCRYPT) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {1'b0, exp_res};
                m_axis_tlast  <= 1'b0;
              end else begin
                first <= exp_res;
              end
              phase <= 1'b1;
              mp    <= {1'b0, op2};
              mc    <= {{(ModW-1){1'b0}}, 1'b1};
              macc  <= '0;
              cnt   <= '0;
              e_sh  <= exponent;
              acc   <= {{(ModW-1){1'b0}}, 1'b1};
              state <= S_RED;
            end
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= 1'b1;
            if (cmd_r == CMD_DECRYPT) begin
              m_axis_tdata <= {first[15:0], 16'h0000} | {1'b0, exp_res};
            end else begin
              m_axis_tdata <= {1'b0, exp_res};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The serial accumulator stays reduced while a multiply runs.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_RED || state == S_MUL || state == S_SQR) && modulus != '0)
      |-> (macc < modulus))
    else $error("serial accumulator left the residue range");

  // The running product stays reduced for a usable modulus.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL || state == S_SQR) && modulus > 31'd1) |-> (acc < modulus))
    else $error("exponentiation accumulator left the residue range");

  // A word without last is only the high half of an encrypt.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (cmd_r == CMD_ENCRYPT && phase))
    else $error("non-final word outside an encrypt");

  // An accepted item keeps the input closed on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (!s_axis_tready && state == S_RED))
    else $error("input reopened right after a word was taken");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: RSA split-word cipher unit
// Drives plaintext and cipher words through the stream ports under several
// key settings and checks every result word against a modular exponentiation
// predictor. The sender and the receiver idle at random, and the receiver
// once holds off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module testbench;
  import rsawc_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             last;
  } cipher_word_t;

  class cipher_scoreboard;
    logic [ExpW-1:0] key_exponent;
    logic [ModW-1:0] key_modulus;
    cipher_word_t    words_due[$];
    int              failures;

    function new();
      key_exponent = EXPONENT_RESET;
      key_modulus  = MODULUS_RESET;
      failures     = 0;
    endfunction

    function void set_register(logic [IdxW-1:0] index, logic [31:0] data);
      case (index)
        REG_EXPONENT: key_exponent = data;
        REG_MODULUS:  key_modulus  = data[ModW-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] power_mod(logic [31:0] base);
      logic [63:0] acc;
      logic [63:0] sq;
      if (key_exponent == 0) return 32'd1;
      if (key_modulus == 0) return 32'd0;
      acc = 64'd1;
      sq  = {32'd0, base} % {33'd0, key_modulus};
      for (int i = 0; i < ExpW; i++) begin
        if (key_exponent[i]) acc = (acc * sq) % {33'd0, key_modulus};
        sq = (sq * sq) % {33'd0, key_modulus};
      end
      return acc[31:0];
    endfunction

    function void add_due(logic [31:0] result_word, logic last);
      cipher_word_t entry;
      entry.result_word = result_word;
      entry.last        = last;
      words_due         = {words_due, entry};
    endfunction

    function void note_input(logic cmd, logic [31:0] word_a, logic [30:0] word_b);
      logic [31:0] high_part;
      logic [31:0] low_part;
      logic [31:0] joined;
      if (cmd == CMD_ENCRYPT) begin
        high_part = power_mod((word_a >> HALF_SHIFT) & HALF_MASK);
        low_part  = power_mod(word_a & HALF_MASK);
        add_due(high_part, 1'b0);
        add_due(low_part, 1'b1);
      end else begin
        high_part = power_mod(word_a);
        low_part  = power_mod({1'b0, word_b});
        joined    = high_part << HALF_SHIFT;
        joined    = joined | low_part;
        add_due(joined, 1'b1);
      end
    endfunction

    function void check_result(logic [31:0] result_word, logic last);
      cipher_word_t want;
      if (words_due.size() == 0) begin
        $error("unexpected result word %h", result_word);
        failures++;
        return;
      end
      want = words_due.pop_front();
      if (result_word !== want.result_word) begin
        $error("result_word mismatch: expected %h, actual %h", want.result_word, result_word);
        failures++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [WordW-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index = REG_EXPONENT;
  logic [31:0]       cfg_data = '0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_req = 0;
  int rx_wait = 0;

  cipher_scoreboard board = new();

  always #4 clk = ~clk;

  rsa_split_word_modexp_cipher_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[62:32]);
      end
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        rx_wait = hold_req;
        hold_req = 0;
      end
      if (rx_wait == 0 && rx_idle && $urandom_range(0, 5) == 0) rx_wait = $urandom_range(1, 8);
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [31:0] word_a,
                           input logic [30:0] word_b);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, word_b, word_a};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic set_key(input logic [31:0] exponent, input logic [30:0] modulus);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EXPONENT;
    cfg_data  <= exponent;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MODULUS;
    cfg_data  <= {1'b0, modulus};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int          random_sent;
    int          phase_no;
    int          phase_items;
    logic [31:0] exponent;
    logic [30:0] modulus;
    logic [31:0] word_a;
    logic        cmd;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default key first, then the exponent and modulus extremes.
    send_word(CMD_ENCRYPT, 32'h0000_0000, 31'h1234_5678);
    send_word(CMD_ENCRYPT, 32'hFFFF_FFFF, 31'h0);
    send_word(CMD_ENCRYPT, 32'h8000_0001, 31'h7FFF_FFFF);
    send_word(CMD_DECRYPT, 32'h0000_0000, 31'h0);
    send_word(CMD_DECRYPT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_word(CMD_DECRYPT, 32'h7FFF_FFFE, 31'h7FFF_FFFF);
    send_word(CMD_DECRYPT, 32'h0000_0002, 31'h0000_0003);
    finish_phase();

    set_key(32'd0, 31'h7FFF_FFFF);
    send_word(CMD_ENCRYPT, 32'h1234_ABCD, 31'h5555_5555);
    send_word(CMD_DECRYPT, 32'hFFFF_FFFF, 31'h0);
    finish_phase();

    set_key(32'hFFFF_FFFF, 31'd2);
    send_word(CMD_ENCRYPT, 32'hFFFF_0000, 31'h0);
    send_word(CMD_DECRYPT, 32'h0000_0005, 31'h7FFF_FFFF);
    finish_phase();

    set_key(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_word(CMD_ENCRYPT, 32'hDEAD_BEEF, 31'h2AAA_AAAA);
    send_word(CMD_DECRYPT, 32'h8000_0000, 31'h4000_0000);
    finish_phase();

    set_key(32'd1, 31'd3);
    send_word(CMD_ENCRYPT, 32'hFFFF_FFFF, 31'h0);
    send_word(CMD_DECRYPT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    finish_phase();

    random_sent = 0;
    phase_no = 0;
    while (random_sent < 125) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: exponent = $urandom_range(1, 255);
        5, 6, 7:       exponent = $urandom_range(0, 65535);
        8:             exponent = $urandom;
        default:       exponent = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
      case ($urandom_range(0, 3))
        0:       modulus = 31'($urandom_range(2, 255));
        1:       modulus = 31'($urandom_range(256, 65535));
        default: modulus = 31'($urandom_range(2, 32'h7FFF_FFFF));
      endcase
      tx_idle = random_sent < 105;
      rx_idle = random_sent < 105;
      phase_items = $urandom_range(4, 12);
      if (phase_no == 2) begin
        // Short exponent so that words finish quickly and pile up behind
        // the stalled receiver.
        exponent = $urandom_range(2, 7);
        tx_idle = 1'b0;
        phase_items = 12;
      end
      set_key(exponent, modulus);
      if (phase_no == 2) hold_req = 3000;
      repeat (phase_items) begin
        cmd = 1'($urandom_range(0, 1));
        word_a = $urandom;
        if ($urandom_range(0, 7) == 0) word_a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        send_word(cmd, word_a, 31'($urandom));
      end
      random_sent += phase_items;
      finish_phase();
      phase_no++;
    end

    for (int n = 0; n < 20000 && board.pending() != 0; n++) @(posedge clk);
    repeat (4500) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected result words never arrived", board.pending());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== rsa_split_word_modexp_cipher_unit.f =====
hdl/rsawc_pkg.sv
hdl/rsa_split_word_modexp_cipher_unit.sv
dv/testbench.sv
